// ===== design/tcas_pkg.sv =====
`default_nettype none

package tcas_pkg;

  // Common width for comparing coordinates against sizes up to 256
  localparam int CMP_W = 9;

  localparam logic [3:0] DIGIT_MAX    = 4'd9;
  localparam logic [6:0] RESET_WIDTH  = 7'd60;
  localparam logic [5:0] RESET_HEIGHT = 6'd29;

  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  // Last sub-step of a cell update: four neighbour reads, then the write-back
  localparam logic [2:0] PH_LAST = 3'd4;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    NBR_LEFT  = 2'd0,
    NBR_UP    = 2'd1,
    NBR_RIGHT = 2'd2,
    NBR_DOWN  = 2'd3
  } nbr_t;

  typedef struct packed {
    logic restart;
    logic advance;
    logic nbr_en;
    nbr_t nbr;
  } scan_ctl_t;

  typedef struct packed {
    logic last;
  } scan_sts_t;

endpackage

`default_nettype wire

// ===== design/tcas_ram.sv =====
`default_nettype none

module tcas_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/tcas_scan.sv =====
`default_nettype none

module tcas_scan
  import tcas_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 32,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int AW = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire scan_ctl_t     ctl,
  input  wire logic [WW-1:0] w_eff,
  input  wire logic [HW-1:0] h_eff,
  output logic      [AW-1:0] addr,
  output scan_sts_t          sts
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [XW-1:0] cx_r, cx_nxt, nx_c;
  logic [YW-1:0] cy_r, cy_nxt, ny_c;
  logic [WW-1:0] wm1_c;
  logic [HW-1:0] hm1_c;
  logic          last_x_c, last_y_c;

  assign wm1_c    = WW'(w_eff - WW'(1));
  assign hm1_c    = HW'(h_eff - HW'(1));
  assign last_x_c = (CMP_W'(cx_r) == CMP_W'(wm1_c));
  assign last_y_c = (CMP_W'(cy_r) == CMP_W'(hm1_c));
  assign sts.last = last_x_c && last_y_c;

  // Neighbour coordinates, wrapping at the edges of the area in use
  always_comb begin
    nx_c = cx_r;
    ny_c = cy_r;
    if (ctl.nbr_en) begin
      case (ctl.nbr)
        NBR_LEFT:  nx_c = (cx_r == '0) ? XW'(wm1_c) : XW'(cx_r - XW'(1));
        NBR_RIGHT: nx_c = last_x_c ? '0 : XW'(cx_r + XW'(1));
        NBR_UP:    ny_c = (cy_r == '0) ? YW'(hm1_c) : YW'(cy_r - YW'(1));
        NBR_DOWN:  ny_c = last_y_c ? '0 : YW'(cy_r + YW'(1));
        default:   nx_c = cx_r;
      endcase
    end
  end

  assign addr = AW'(ny_c) * AW'(MAX_WIDTH) + AW'(nx_c);

  always_comb begin
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    if (ctl.restart) begin
      cx_nxt = '0;
      cy_nxt = '0;
    end else if (ctl.advance) begin
      if (last_x_c) begin
        cx_nxt = '0;
        cy_nxt = last_y_c ? '0 : YW'(cy_r + YW'(1));
      end else begin
        cx_nxt = XW'(cx_r + XW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
    end else begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/torus_cellular_automaton_step_unit.sv =====
// Torus cellular automaton step unit.
// Input stream (in_*): one command per transfer: write a digit, read a digit,
// or advance the whole grid one generation. Each command gives exactly one
// result transfer on the output stream (out_*): the digit read and a status
// bit that flags a coordinate outside the configured grid.
// Grid size is set through the cfg_* write port; the user must write it only
// while the unit is idle, as the unit does not enforce this. A write or read
// passes through the done state; its result is registered in the output
// register. A step walks the grid twice through the two-port memories: one
// pass copies every live flag into the snapshot memory, then each cell reads
// its four neighbours one per cycle and writes back. One command is in flight
// at a time; in_tready is high only when idle. After reset all cells of the
// cell memory, MAX_WIDTH*MAX_HEIGHT (2048 by default), are swept to zero, one
// cell a cycle; no command is taken then, configuration writes are. A stalled
// receiver holds the result in the output register; the next command is still
// accepted and its result waits for it.
`default_nettype none

module torus_cellular_automaton_step_unit
  import tcas_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // cmd[1:0], x[7:2], y[12:8], value[16:13]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,  // read_value[3:0], status[4]
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_COPY  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_NBR   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [6:0]    w_cfg_r;
  logic [5:0]    h_cfg_r;
  cmd_t          cmd_r, cmd_nxt;
  logic          bad_r, bad_nxt;
  logic [2:0]    ph_r, ph_nxt;
  logic [2:0]    acc_r, acc_nxt;
  logic          copy_pend_r, copy_pend_nxt;
  logic [AW-1:0] copy_addr_r, copy_addr_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [7:0]    out_tdata_r, out_tdata_nxt;

  logic [WW-1:0] w_eff_c;
  logic [HW-1:0] h_eff_c;

  cmd_t          in_cmd_c;
  logic [5:0]    in_x_c;
  logic [4:0]    in_y_c;
  logic [3:0]    in_val_c, val_sat_c;
  logic          in_fire_c, in_bad_c, out_free_c;
  logic [AW-1:0] in_addr_c;

  logic          cell_we, cell_re;
  logic [AW-1:0] cell_waddr, cell_raddr;
  logic [3:0]    cell_wdata, cell_rdata;
  logic          snap_re;
  logic [0:0]    snap_rdata;

  scan_ctl_t     scan_ctl;
  scan_sts_t     scan_sts;
  logic [AW-1:0] scan_addr;

  logic [2:0]    sum_c;
  logic          alive_c;
  logic [3:0]    rd_val_c;

  // Effective grid size: zero counts as one, oversize as the maximum
  always_comb begin
    if (w_cfg_r == '0) begin
      w_eff_c = WW'(1);
    end else if (CMP_W'(w_cfg_r) > CMP_W'(MAX_WIDTH)) begin
      w_eff_c = WW'(MAX_WIDTH);
    end else begin
      w_eff_c = WW'(w_cfg_r);
    end
    if (h_cfg_r == '0) begin
      h_eff_c = HW'(1);
    end else if (CMP_W'(h_cfg_r) > CMP_W'(MAX_HEIGHT)) begin
      h_eff_c = HW'(MAX_HEIGHT);
    end else begin
      h_eff_c = HW'(h_cfg_r);
    end
  end

  assign in_cmd_c   = cmd_t'(in_tdata[1:0]);
  assign in_x_c     = in_tdata[7:2];
  assign in_y_c     = in_tdata[12:8];
  assign in_val_c   = in_tdata[16:13];
  assign val_sat_c  = (in_val_c > DIGIT_MAX) ? DIGIT_MAX : in_val_c;
  assign in_addr_c  = AW'(in_y_c) * AW'(MAX_WIDTH) + AW'(in_x_c);
  assign in_bad_c   = ((in_cmd_c == CMD_WRITE) || (in_cmd_c == CMD_READ)) &&
                      ((CMP_W'(in_x_c) >= CMP_W'(w_eff_c)) ||
                       (CMP_W'(in_y_c) >= CMP_W'(h_eff_c)));

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire_c  = in_tvalid && in_tready;
  assign out_free_c = !out_tvalid_r || out_tready;

  assign sum_c    = acc_r + {2'b00, snap_rdata};
  assign alive_c  = (sum_c == 3'd2) || (sum_c == 3'd3);
  assign rd_val_c = ((cmd_r == CMD_READ) && !bad_r) ? cell_rdata : 4'd0;

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    cmd_nxt        = cmd_r;
    bad_nxt        = bad_r;
    ph_nxt         = ph_r;
    acc_nxt        = acc_r;
    copy_pend_nxt  = 1'b0;
    copy_addr_nxt  = copy_addr_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    cell_we        = 1'b0;
    cell_waddr     = scan_addr;
    cell_wdata     = 4'd0;
    cell_re        = 1'b0;
    cell_raddr     = scan_addr;
    snap_re        = 1'b0;
    scan_ctl       = '{restart: 1'b0, advance: 1'b0, nbr_en: 1'b0, nbr: NBR_LEFT};

    case (state_r)
      ST_CLEAR: begin
        cell_we      = 1'b1;
        cell_waddr   = clr_addr_r;
        clr_addr_nxt = AW'(clr_addr_r + AW'(1));
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        scan_ctl.restart = 1'b1;
        if (in_fire_c) begin
          cmd_nxt    = in_cmd_c;
          bad_nxt    = in_bad_c;
          cell_re    = 1'b1;
          cell_raddr = in_addr_c;
          if ((in_cmd_c == CMD_WRITE) && !in_bad_c) begin
            cell_we    = 1'b1;
            cell_waddr = in_addr_c;
            cell_wdata = val_sat_c;
          end
          state_nxt = (in_cmd_c == CMD_STEP) ? ST_COPY : ST_DONE;
        end
      end
      ST_COPY: begin
        // read a cell now, write its live flag to the snapshot next cycle
        cell_re       = 1'b1;
        copy_pend_nxt = 1'b1;
        copy_addr_nxt = scan_addr;
        if (scan_sts.last) begin
          scan_ctl.restart = 1'b1;
          state_nxt        = ST_DRAIN;
        end else begin
          scan_ctl.advance = 1'b1;
        end
      end
      ST_DRAIN: begin
        ph_nxt    = 3'd0;
        state_nxt = ST_NBR;
      end
      ST_NBR: begin
        scan_ctl.nbr_en = (ph_r != PH_LAST);
        scan_ctl.nbr    = nbr_t'(ph_r[1:0]);
        snap_re         = (ph_r != PH_LAST);
        acc_nxt         = (ph_r == 3'd0) ? 3'd0 : sum_c;
        if (ph_r == PH_LAST) begin
          cell_we    = 1'b1;
          cell_wdata = {3'b000, alive_c};
          ph_nxt     = 3'd0;
          if (scan_sts.last) begin
            state_nxt = ST_DONE;
          end else begin
            scan_ctl.advance = 1'b1;
          end
        end else begin
          ph_nxt = 3'(ph_r + 3'd1);
        end
      end
      ST_DONE: begin
        if (out_free_c) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {3'b000, bad_r, rd_val_c};
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      w_cfg_r      <= RESET_WIDTH;
      h_cfg_r      <= RESET_HEIGHT;
      ph_r         <= 3'd0;
      acc_r        <= 3'd0;
      copy_pend_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      ph_r         <= ph_nxt;
      acc_r        <= acc_nxt;
      copy_pend_r  <= copy_pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_GRID_WIDTH) begin
          w_cfg_r <= cfg_wdata;
        end else begin
          h_cfg_r <= cfg_wdata[5:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    bad_r       <= bad_nxt;
    copy_addr_r <= copy_addr_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  tcas_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .w_eff (w_eff_c),
    .h_eff (h_eff_c),
    .addr  (scan_addr),
    .sts   (scan_sts)
  );

  tcas_ram #(
    .WIDTH (4),
    .DEPTH (DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cell_re),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  tcas_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_snap_ram (
    .clk   (clk),
    .we    (copy_pend_r),
    .waddr (copy_addr_r),
    .wdata (cell_rdata != 4'd0),
    .re    (snap_re),
    .raddr (scan_addr),
    .rdata (snap_rdata)
  );

`ifndef NO_ASSERTIONS
  // A result appears only on leaving the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside the done state");

  // Snapshot writes only follow copy-pass reads
  a_snap_write_after_copy: assert property (@(posedge clk) disable iff (!rst_n)
    copy_pend_r |-> $past(state_r) == ST_COPY)
    else $error("snapshot write without a copy-pass read");

  // At most four live neighbours reach the write-back
  a_nbr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NBR && ph_r == PH_LAST) |-> sum_c <= 3'd4)
    else $error("neighbour count above four");
`endif

endmodule

`default_nettype wire

// ===== sim/torus_step_checker.sv =====
`timescale 1ns / 100ps

module torus_step_checker
  import tcas_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,   // cmd[1:0], x[7:2], y[12:8], value[16:13]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,  // read_value[3:0], status[4]
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_wdata,
  output int               mismatches,
  output int               outstanding,
  output int               checked
);

  localparam int COLS = 64;
  localparam int ROWS = 32;

  typedef struct packed {
    logic [3:0] digit;
    logic       off_grid;
  } answer_t;

  logic [3:0] cells [COLS*ROWS];
  logic       alive_then [COLS*ROWS];
  logic [6:0] width_reg;
  logic [5:0] height_reg;
  answer_t    pending_answers [$];

  function automatic int fit_size(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void advance_generation(input int w, input int h);
    int cx, cy, up, down, lf, rt, alive;
    for (cy = 0; cy < h; cy++)
      for (cx = 0; cx < w; cx++)
        alive_then[cy*COLS + cx] = (cells[cy*COLS + cx] != 4'd0);
    for (cy = 0; cy < h; cy++) begin
      up   = (cy + h - 1) % h;
      down = (cy + 1) % h;
      for (cx = 0; cx < w; cx++) begin
        lf = (cx + w - 1) % w;
        rt = (cx + 1) % w;
        alive = int'(alive_then[cy*COLS + lf]) + int'(alive_then[up*COLS + cx])
              + int'(alive_then[cy*COLS + rt]) + int'(alive_then[down*COLS + cx]);
        cells[cy*COLS + cx] = (alive == 2 || alive == 3) ? 4'd1 : 4'd0;
      end
    end
  endfunction

  function automatic answer_t apply_to_grid(input logic [1:0] cmd, input logic [5:0] x,
                                            input logic [4:0] y, input logic [3:0] v);
    int w, h, addr;
    answer_t ans;
    w = fit_size(int'(width_reg), COLS);
    h = fit_size(int'(height_reg), ROWS);
    addr = int'(y) * COLS + int'(x);
    ans = '0;
    case (cmd)
      CMD_WRITE, CMD_READ: begin
        if (int'(x) >= w || int'(y) >= h) ans.off_grid = 1'b1;
        else if (cmd == CMD_WRITE) cells[addr] = (v > DIGIT_MAX) ? DIGIT_MAX : v;
        else ans.digit = cells[addr];
      end
      CMD_STEP: advance_generation(w, h);
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want, got;
    int errs, done;
    errs = 0;
    done = 0;
    if (!rst_n) begin
      foreach (cells[i]) cells[i] = 4'd0;
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      pending_answers.delete();
      mismatches  <= 0;
      outstanding <= 0;
      checked     <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.digit    = out_tdata[3:0];
        got.off_grid = out_tdata[4];
        if (pending_answers.size() == 0) begin
          $display("%0t: result with nothing expected: read_value %0d status %0d",
                   $time, got.digit, got.off_grid);
          errs++;
        end else begin
          want = pending_answers.pop_front();
          done = 1;
          if (want.digit !== got.digit) begin
            $display("%0t: read_value expected %0d, actual %0d", $time, want.digit, got.digit);
            errs++;
          end
          if (want.off_grid !== got.off_grid) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.off_grid, got.off_grid);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_answers.push_back(apply_to_grid(in_tdata[1:0], in_tdata[7:2],
                                                in_tdata[12:8], in_tdata[16:13]));
      if (cfg_we) begin
        if (cfg_index == CFG_GRID_WIDTH) width_reg = cfg_wdata;
        else height_reg = cfg_wdata[5:0];
      end
      mismatches  <= mismatches + errs;
      checked     <= checked + done;
      outstanding <= pending_answers.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import tcas_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // cmd[1:0], x[7:2], y[12:8], value[16:13]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // read_value[3:0], status[4]
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        no_idle = 1'b0;

  int mismatches, outstanding, checked;
  int n_writes, n_reads, n_steps, n_unused, n_sizes;

  torus_cellular_automaton_step_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  torus_step_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .checked    (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 19);
  end

  // Valid stays high across back-to-back transfers; it is lowered only for a gap or when settling
  task automatic issue(input logic [1:0] c, input logic [5:0] x, input logic [4:0] y,
                       input logic [3:0] v);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 19) gap = int'($urandom_range(4, 1));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, v, y, x, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (c)
      CMD_WRITE: n_writes++;
      CMD_READ:  n_reads++;
      CMD_STEP:  n_steps++;
      default:   n_unused++;
    endcase
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_grid(input logic [6:0] w_raw, input logic [6:0] h_raw);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_wdata <= w_raw;
    @(posedge clk);
    cfg_index <= CFG_GRID_HEIGHT;
    cfg_wdata <= h_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Move one place left/right (or up/down) or stay, at random, wrapping on the torus
  function automatic int nudge(input int c, input int n);
    return (c + n + int'($urandom_range(2)) - 1) % n;
  endfunction

  task automatic run_phase(input logic [6:0] w_raw, input logic [6:0] h_raw,
                           input int n_items, input int step_cap);
    int w, h, steps, sent, k, burst, bx, by;
    logic [1:0] c;
    settle();
    set_grid(w_raw, h_raw);
    n_sizes++;
    w = (w_raw == 7'd0) ? 1 : ((int'(w_raw) > 64) ? 64 : int'(w_raw));
    h = (h_raw[5:0] == 6'd0) ? 1 : ((int'(h_raw[5:0]) > 32) ? 32 : int'(h_raw[5:0]));
    steps = 0;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 70) begin
        // seed a cluster of cells, advance if the step cap allows, then read the neighbourhood
        bx = int'($urandom_range(w - 1));
        by = int'($urandom_range(h - 1));
        burst = int'($urandom_range(5, 2));
        for (k = 0; k < burst; k++)
          issue(CMD_WRITE, 6'(nudge(bx, w)), 5'(nudge(by, h)), 4'($urandom_range(15)));
        if (steps < step_cap) begin
          issue(CMD_STEP, 6'($urandom_range(63)), 5'($urandom_range(31)),
                4'($urandom_range(15)));
          steps++;
          sent++;
        end
        for (k = 0; k < burst; k++)
          issue(CMD_READ, 6'(nudge(bx, w)), 5'(nudge(by, h)), 4'($urandom_range(15)));
        sent += 2 * burst;
      end else begin
        c = 2'($urandom_range(3));
        if (c == CMD_STEP && steps >= step_cap) c = CMD_READ;
        if (c == CMD_STEP) steps++;
        issue(c, 6'($urandom_range(63)), 5'($urandom_range(31)), 4'($urandom_range(15)));
        sent++;
      end
    end
  endtask

  initial begin
    n_writes = 0;
    n_reads  = 0;
    n_steps  = 0;
    n_unused = 0;
    n_sizes  = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset size of 60 by 29
    issue(CMD_WRITE, 6'd0, 5'd0, 4'd5);
    issue(CMD_WRITE, 6'd59, 5'd28, 4'd15);
    issue(CMD_WRITE, 6'd63, 5'd31, 4'd7);
    issue(CMD_WRITE, 6'd60, 5'd0, 4'd1);
    issue(CMD_WRITE, 6'd0, 5'd29, 4'd1);
    issue(CMD_WRITE, 6'd1, 5'd0, 4'd1);
    issue(CMD_WRITE, 6'd59, 5'd0, 4'd2);
    issue(CMD_WRITE, 6'd0, 5'd28, 4'd4);
    issue(CMD_WRITE, 6'd1, 5'd1, 4'd0);
    issue(CMD_READ, 6'd0, 5'd0, 4'd0);
    issue(CMD_READ, 6'd59, 5'd28, 4'd15);
    issue(CMD_READ, 6'd60, 5'd28, 4'd0);
    issue(CMD_READ, 6'd63, 5'd31, 4'd0);
    issue(CMD_READ, 6'd30, 5'd14, 4'd0);
    issue(CMD_UNUSED, 6'd63, 5'd31, 4'd15);
    issue(CMD_STEP, 6'd63, 5'd31, 4'd15);
    issue(CMD_READ, 6'd0, 5'd0, 4'd0);
    issue(CMD_READ, 6'd59, 5'd0, 4'd0);
    issue(CMD_READ, 6'd0, 5'd28, 4'd0);
    issue(CMD_READ, 6'd58, 5'd28, 4'd0);
    issue(CMD_READ, 6'd59, 5'd28, 4'd0);
    issue(CMD_WRITE, 6'd0, 5'd0, 4'd9);

    run_phase(7'd64, 7'd32, 30, 2);
    run_phase(7'd1, 7'd1, 25, 6);
    run_phase(7'd0, 7'd0, 20, 5);
    run_phase(7'd127, 7'd127, 25, 1);
    no_idle <= 1'b1;
    run_phase(7'd5, 7'd3, 30, 8);
    no_idle <= 1'b0;
    run_phase(7'd2, 7'd2, 25, 8);
    run_phase(7'd0, 7'd7, 20, 6);
    run_phase(7'd3, 7'd64, 15, 5);
    run_phase(7'd9, 7'd63, 25, 5);
    run_phase(7'($urandom_range(12, 1)), 7'($urandom_range(8, 1)), 30, 8);
    run_phase(7'd60, 7'd29, 30, 1);

    settle();
    repeat (10) @(posedge clk);
    $display("Issued %0d writes, %0d reads, %0d generation steps and %0d unused codes",
             n_writes, n_reads, n_steps, n_unused);
    $display("across %0d grid sizes; %0d results compared", n_sizes, checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
